// ===== src/rrcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrcd_pkg
// Types and constants shared by the round-robin capture demultiplexer.
// ----------------------------------------------------------------------------
package rrcd_pkg;

  localparam int unsigned DEF_BUFFER_DEPTH = 1024;
  localparam int unsigned DEF_CHANNELS     = 3;

  localparam int unsigned COUNT_W = 11;
  localparam int unsigned MASK_W  = 3;
  localparam int unsigned POS_W   = 2;
  localparam int unsigned WIDX_W  = 10;
  localparam int unsigned VALUE_W = 12;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CFG_W   = 11;

  localparam int unsigned WORD_ERROR_BIT = 15;

  // request codes
  localparam logic [1:0] REQ_ARM   = 2'd0;
  localparam logic [1:0] REQ_KICK  = 2'd1;
  localparam logic [1:0] REQ_WORD  = 2'd2;
  localparam logic [1:0] REQ_ABORT = 2'd3;

  // configuration register indexes
  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_CHANNEL_MASK = 1'b1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [WORD_W-1:0] sample_word;
    logic              fifo_overrun;
  } req_t;

  typedef struct packed {
    logic               write_valid;
    logic [1:0]         write_channel;
    logic [WIDX_W-1:0]  write_index;
    logic [VALUE_W-1:0] sample_value;
    logic               converter_run;
    logic               armed_flag;
    logic               error_seen;
    logic               capture_done;
    logic               capture_ok;
  } rsp_t;

endpackage

// ===== src/round_robin_capture_demux.sv =====
// ----------------------------------------------------------------------------
// round_robin_capture_demux
// Routes round-robin converter words to (channel, sample slot) writes.
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid/req_stall/req) carries arm, kick, abort and
//   converter-word transactions; every accepted request yields exactly one
//   response on the rsp channel (rsp_valid/rsp_stall/rsp).
//   cfg channel (cfg_valid/cfg_ready) writes sample_count (index 0) and
//   channel_mask (index 1); cfg_ready is always high. write only while idle.
//   the response is registered: rsp_valid rises in the cycle after the request is accepted.
//   throughput: one request per cycle while the receiver does not stall, set by
//   the update of the capture counters and the one-entry result register.
//   when the receiver stalls, the result register holds its response and
//   req_stall rises in the same cycle, so no transaction is lost.
//   reset (rst, synchronous) clears the registers, disarms the capture and
//   empties the result register.
//   enabled channels are visited highest first (2, 1, 0).
// ----------------------------------------------------------------------------
module round_robin_capture_demux #(
  parameter int unsigned BUFFER_DEPTH = rrcd_pkg::DEF_BUFFER_DEPTH,
  parameter int unsigned CHANNELS     = rrcd_pkg::DEF_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  rrcd_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output rrcd_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [rrcd_pkg::CFG_W-1:0] cfg_data
);

  logic [rrcd_pkg::COUNT_W-1:0] sample_count;
  logic [rrcd_pkg::MASK_W-1:0]  channel_mask;
  logic                         open;
  logic                         accept;
  rrcd_pkg::rsp_t               core_rsp;

  assign cfg_ready = 1'b1;
  assign req_stall = ~open;
  assign accept    = req_valid & open;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      channel_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rrcd_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data[rrcd_pkg::COUNT_W-1:0];
        rrcd_pkg::REG_CHANNEL_MASK: channel_mask <= cfg_data[rrcd_pkg::MASK_W-1:0];
        default: sample_count <= sample_count;
      endcase
    end
  end

  rrcd_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .CHANNELS    (CHANNELS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req         (req),
    .sample_count(sample_count),
    .channel_mask(channel_mask),
    .rsp         (core_rsp)
  );

  rrcd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .load_data(core_rsp),
    .open     (open),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

// ===== src/rrcd_core.sv =====
// ----------------------------------------------------------------------------
// rrcd_core
// Capture state and per-transaction logic: arm, kick, abort and word routing.
// ----------------------------------------------------------------------------
module rrcd_core #(
  parameter int unsigned BUFFER_DEPTH = rrcd_pkg::DEF_BUFFER_DEPTH,
  parameter int unsigned CHANNELS     = rrcd_pkg::DEF_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  rrcd_pkg::req_t               req,
  input  logic [rrcd_pkg::COUNT_W-1:0] sample_count,
  input  logic [rrcd_pkg::MASK_W-1:0]  channel_mask,
  output rrcd_pkg::rsp_t               rsp
);

  localparam logic [rrcd_pkg::MASK_W-1:0] USABLE =
    rrcd_pkg::MASK_W'((1 << CHANNELS) - 1);

  logic                         armed, armed_next;
  logic                         running, running_next;
  logic [rrcd_pkg::POS_W-1:0]   channel_position, channel_position_next;
  logic [rrcd_pkg::COUNT_W-1:0] sample_index, sample_index_next;
  logic                         error_sticky, error_sticky_next;
  logic [rrcd_pkg::COUNT_W-1:0] latched_count, latched_count_next;
  logic [rrcd_pkg::MASK_W-1:0]  latched_mask, latched_mask_next;

  logic [rrcd_pkg::MASK_W-1:0]  arm_mask;
  logic [rrcd_pkg::COUNT_W-1:0] arm_count;
  logic [rrcd_pkg::POS_W-1:0]   active;
  logic [rrcd_pkg::POS_W-1:0]   pos_inc;
  logic [rrcd_pkg::COUNT_W-1:0] idx_inc;
  logic [1:0]                   sel_channel;
  logic [rrcd_pkg::POS_W-1:0]   seen;

  assign arm_mask = channel_mask & USABLE;
  assign arm_count = ({21'd0, sample_count} > 32'(BUFFER_DEPTH)) ?
                     rrcd_pkg::COUNT_W'(BUFFER_DEPTH) : sample_count;
  assign active = rrcd_pkg::POS_W'($countones(latched_mask));
  assign pos_inc = channel_position + 1'b1;
  assign idx_inc = sample_index + 1'b1;

  // enabled channels, highest first
  always_comb begin
    sel_channel = 2'd0;
    seen = '0;
    for (int ch = CHANNELS - 1; ch >= 0; ch--) begin
      if (latched_mask[ch]) begin
        if (seen == channel_position) begin
          sel_channel = 2'(ch);
        end
        seen = seen + 1'b1;
      end
    end
  end

  always_comb begin
    armed_next            = armed;
    running_next          = running;
    channel_position_next = channel_position;
    sample_index_next     = sample_index;
    error_sticky_next     = error_sticky;
    latched_count_next    = latched_count;
    latched_mask_next     = latched_mask;
    rsp                   = '0;

    case (req.req_type)
      rrcd_pkg::REQ_ARM: begin
        armed_next   = 1'b0;
        running_next = 1'b0;
        if (sample_count != '0 && arm_mask != '0) begin
          latched_count_next    = arm_count;
          latched_mask_next     = arm_mask;
          channel_position_next = '0;
          sample_index_next     = '0;
          error_sticky_next     = 1'b0;
          armed_next            = 1'b1;
        end
      end
      rrcd_pkg::REQ_KICK: begin
        if (armed) begin
          running_next = 1'b1;
        end
      end
      rrcd_pkg::REQ_WORD: begin
        if (running && active != '0 && sample_index < latched_count) begin
          error_sticky_next = error_sticky | req.fifo_overrun |
                              req.sample_word[rrcd_pkg::WORD_ERROR_BIT];
          rsp.write_valid   = 1'b1;
          rsp.write_channel = sel_channel;
          rsp.write_index   = sample_index[rrcd_pkg::WIDX_W-1:0];
          rsp.sample_value  = req.sample_word[rrcd_pkg::VALUE_W-1:0];
          if (pos_inc >= active) begin
            channel_position_next = '0;
            sample_index_next     = idx_inc;
          end else begin
            channel_position_next = pos_inc;
          end
          if (sample_index_next >= latched_count) begin
            rsp.capture_done = 1'b1;
            rsp.capture_ok   = ~error_sticky_next;
            armed_next       = 1'b0;
            running_next     = 1'b0;
          end
        end
      end
      rrcd_pkg::REQ_ABORT: begin
        armed_next   = 1'b0;
        running_next = 1'b0;
      end
      default: begin
        armed_next   = armed;
        running_next = running;
      end
    endcase

    rsp.converter_run = running_next;
    rsp.armed_flag    = armed_next;
    rsp.error_seen    = error_sticky_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed            <= 1'b0;
      running          <= 1'b0;
      channel_position <= '0;
      sample_index     <= '0;
      error_sticky     <= 1'b0;
      latched_count    <= '0;
      latched_mask     <= '0;
    end else if (accept) begin
      armed            <= armed_next;
      running          <= running_next;
      channel_position <= channel_position_next;
      sample_index     <= sample_index_next;
      error_sticky     <= error_sticky_next;
      latched_count    <= latched_count_next;
      latched_mask     <= latched_mask_next;
    end
  end

endmodule

// ===== src/rrcd_out_reg.sv =====
// ----------------------------------------------------------------------------
// rrcd_out_reg
// Result register: holds one response until the receiver takes it.
// ----------------------------------------------------------------------------
module rrcd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  rrcd_pkg::rsp_t load_data,
  output logic           open,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rrcd_pkg::rsp_t rsp
);

  // free when empty or being drained this cycle
  assign open = ~rsp_valid | ~rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (open) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && open) begin
      rsp <= load_data;
    end
  end

endmodule

// ===== tb/round_robin_capture_demux_checker.sv =====
// ----------------------------------------------------------------------------
// round_robin_capture_demux_checker
// Watches the request, response and register channels of the capture
// demultiplexer. Keeps its own copy of the capture state, predicts the
// response to every accepted request and compares the responses field by
// field, in order.
// ----------------------------------------------------------------------------
module round_robin_capture_demux_checker
  import rrcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  req_t               req,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  rsp_t               rsp,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output int                 mismatches,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = DEF_BUFFER_DEPTH;

  // register copies
  logic [COUNT_W-1:0] set_count;
  logic [MASK_W-1:0]  set_mask;

  // capture state
  logic               armed;
  logic               running;
  logic [POS_W-1:0]   chan_pos;
  logic [COUNT_W-1:0] slot;
  logic               err_sticky;
  logic [COUNT_W-1:0] cap_count;
  logic [MASK_W-1:0]  cap_mask;

  rsp_t expected_q[$];

  // enabled channels are visited highest first
  function automatic logic [1:0] visit_channel(input logic [MASK_W-1:0] m,
                                               input logic [POS_W-1:0] pos);
    int seen;
    seen = 0;
    for (int ch = DEF_CHANNELS - 1; ch >= 0; ch--) begin
      if (m[ch]) begin
        if (seen == pos) return 2'(ch);
        seen++;
      end
    end
    return '0;
  endfunction

  function automatic rsp_t capture_step(input req_t r);
    rsp_t        o;
    int unsigned act;
    o = '0;
    case (r.req_type)
      REQ_ARM: begin
        armed   = 1'b0;
        running = 1'b0;
        if (set_count != 0 && set_mask != 0) begin
          cap_count  = (set_count > DEPTH) ? COUNT_W'(DEPTH) : set_count;
          cap_mask   = set_mask;
          chan_pos   = '0;
          slot       = '0;
          err_sticky = 1'b0;
          armed      = 1'b1;
        end
      end
      REQ_KICK: begin
        if (armed && !running) running = 1'b1;
      end
      REQ_WORD: begin
        act = $countones(cap_mask);
        if (running && act != 0 && slot < cap_count) begin
          if (r.sample_word[WORD_ERROR_BIT] || r.fifo_overrun) err_sticky = 1'b1;
          o.write_valid   = 1'b1;
          o.write_channel = visit_channel(cap_mask, chan_pos);
          o.write_index   = slot[WIDX_W-1:0];
          o.sample_value  = r.sample_word[VALUE_W-1:0];
          if (chan_pos + 1 >= act) begin
            chan_pos = '0;
            slot++;
          end else begin
            chan_pos++;
          end
          if (slot >= cap_count) begin
            o.capture_done = 1'b1;
            o.capture_ok   = !err_sticky;
            armed          = 1'b0;
            running        = 1'b0;
          end
        end
      end
      default: begin
        armed   = 1'b0;
        running = 1'b0;
      end
    endcase
    o.converter_run = running;
    o.armed_flag    = armed;
    o.error_seen    = err_sticky;
    return o;
  endfunction

  function automatic logic field_differs(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
    if (got === want) return 1'b0;
    if (mismatches < 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    logic bad;
    if (rst) begin
      set_count  = '0;
      set_mask   = '0;
      armed      = 1'b0;
      running    = 1'b0;
      chan_pos   = '0;
      slot       = '0;
      err_sticky = 1'b0;
      cap_count  = '0;
      cap_mask   = '0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      // responses first: a response never belongs to a request of this edge
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("%0t: response with none expected", $realtime);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          bad  = 1'b0;
          bad |= field_differs("write_valid", want.write_valid, rsp.write_valid);
          bad |= field_differs("write_channel", want.write_channel, rsp.write_channel);
          bad |= field_differs("write_index", want.write_index, rsp.write_index);
          bad |= field_differs("sample_value", want.sample_value, rsp.sample_value);
          bad |= field_differs("converter_run", want.converter_run, rsp.converter_run);
          bad |= field_differs("armed_flag", want.armed_flag, rsp.armed_flag);
          bad |= field_differs("error_seen", want.error_seen, rsp.error_seen);
          bad |= field_differs("capture_done", want.capture_done, rsp.capture_done);
          bad |= field_differs("capture_ok", want.capture_ok, rsp.capture_ok);
          if (bad) mismatches++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SAMPLE_COUNT) set_count = cfg_data[COUNT_W-1:0];
        else set_mask = cfg_data[MASK_W-1:0];
      end
      if (req_valid && !req_stall) expected_q.push_back(capture_step(req));
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/round_robin_capture_demux_tb.sv =====
// ----------------------------------------------------------------------------
// round_robin_capture_demux_tb
// Drives arm, kick, abort and converter-word transactions into the capture
// demultiplexer with random gaps and response stalls, programs the sample
// count and channel mask between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module round_robin_capture_demux_tb;
  import rrcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 60;
  localparam int HOLD_CYCLES   = 150;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  req_t               req;
  logic               rsp_valid;
  logic               rsp_stall;
  rsp_t               rsp;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  int   mismatches;
  int   pending;
  int   cycles;
  int   req_gap;
  logic calm;
  logic hold_rsp;

  round_robin_capture_demux DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  round_robin_capture_demux_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("round_robin_capture_demux_tb: FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // error bit set now and then, the rest of the word fully random
  function automatic logic [WORD_W-1:0] draw_word();
    logic [WORD_W-1:0] w;
    w = WORD_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 15) != 0) w[WORD_ERROR_BIT] = 1'b0;
    return w;
  endfunction

  function automatic logic draw_overrun();
    return $urandom_range(0, 15) == 0;
  endfunction

  // starts and ends just after a falling edge; valid stays up only when
  // the next transaction follows without a gap
  task automatic send(input logic [1:0] kind, input logic [WORD_W-1:0] word,
                      input logic ovr);
    if (req_gap > 0) begin
      req_valid = 1'b0;
      repeat (req_gap) @(negedge clk);
    end
    req.req_type     = kind;
    req.sample_word  = word;
    req.fifo_overrun = ovr;
    req_valid        = 1'b1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    req_gap = draw_gap();
    if (req_gap > 0) req_valid = 1'b0;
  endtask

  task automatic send_word();
    send(REQ_WORD, draw_word(), draw_overrun());
  endtask

  task automatic send_ctrl(input logic [1:0] kind);
    send(kind, WORD_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  // register writes only once every response is back
  task automatic settle();
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] mask);
    settle();
    put_reg(REG_SAMPLE_COUNT, count);
    put_reg(REG_CHANNEL_MASK, mask);
  endtask

  // receiver: random stall before each transaction, one long hold on request
  initial begin
    int stall_len;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
      end
      stall_len = draw_gap();
      if (stall_len > 0) begin
        rsp_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      rsp_stall = 1'b0;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  initial begin
    int          sent;
    int          phase;
    int          total;
    int          extra;
    int unsigned act;
    int unsigned eff;
    logic        cut;
    logic [CFG_W-1:0] cnt;
    logic [CFG_W-1:0] mdata;

    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_rsp  = 1'b0;
    req_gap   = 0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // registers still zero: word and kick ignored, arm refused
    send(REQ_WORD, 16'hFFFF, 1'b1);
    send(REQ_KICK, 16'h0000, 1'b0);
    send(REQ_ARM, 16'h0000, 1'b0);
    send(REQ_ABORT, 16'hFFFF, 1'b1);
    // zero count with channels enabled
    configure(11'd0, 11'd7);
    send(REQ_ARM, 16'h0000, 1'b0);
    // count with no channel enabled, upper data bits set
    configure(11'd1, 11'h7F8);
    send(REQ_ARM, 16'h0000, 1'b0);
    // full three-channel capture with errors, second kick ignored
    configure(11'd2, 11'd7);
    send(REQ_ARM, 16'h0000, 1'b0);
    send(REQ_KICK, 16'h0000, 1'b0);
    send(REQ_KICK, 16'hFFFF, 1'b1);
    send(REQ_WORD, 16'hFFFF, 1'b0);
    send(REQ_WORD, 16'h0000, 1'b0);
    send(REQ_WORD, 16'h7FFF, 1'b0);
    send(REQ_WORD, 16'h0FFF, 1'b1);
    send(REQ_WORD, 16'h1234, 1'b0);
    send(REQ_WORD, 16'h8000, 1'b0);
    send(REQ_WORD, 16'h0555, 1'b0);
    // refused arm keeps the sticky error
    configure(11'd0, 11'd5);
    send(REQ_ARM, 16'h0000, 1'b0);
    // clean two-channel capture, then abort in the middle of another
    configure(11'd1, 11'd5);
    send(REQ_ARM, 16'h0000, 1'b0);
    send(REQ_KICK, 16'h0000, 1'b0);
    send(REQ_WORD, 16'h0ABC, 1'b0);
    send(REQ_WORD, 16'h0123, 1'b0);
    send(REQ_ARM, 16'h0000, 1'b0);
    send(REQ_KICK, 16'h0000, 1'b0);
    send(REQ_WORD, 16'h0AAA, 1'b0);
    send(REQ_ABORT, 16'h0000, 1'b0);
    send(REQ_WORD, 16'h0555, 1'b0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       cnt = '0;
        1:       cnt = CFG_W'($urandom_range(1024, 2047));
        default: cnt = CFG_W'($urandom_range(1, 6));
      endcase
      mdata = CFG_W'($urandom_range(0, 2047));
      if (phase == 1) begin
        cnt   = 11'd12;
        mdata = 11'd7;
      end
      configure(cnt, mdata);
      calm = ($urandom_range(0, 3) == 0);
      // receiver holds off while the sender keeps offering
      if (phase == 1) begin
        calm     = 1'b1;
        hold_rsp = 1'b1;
      end
      send_ctrl(REQ_ARM);
      send_ctrl(REQ_KICK);
      sent += 2;
      act   = $countones(mdata[MASK_W-1:0]);
      eff   = (cnt > DEF_BUFFER_DEPTH) ? DEF_BUFFER_DEPTH : cnt;
      total = eff * act;
      cut   = 1'b0;
      if (total == 0) total = $urandom_range(0, 3);
      if (total > 40) begin
        total = $urandom_range(5, 40);
        cut   = 1'b1;
      end
      extra = $urandom_range(0, 2);
      for (int k = 0; k < total + extra; k++) begin
        if ($urandom_range(0, 29) == 0) send_ctrl(2'($urandom_range(0, 3)));
        send_word();
        sent++;
      end
      if (cut || $urandom_range(0, 7) == 0) begin
        send_ctrl(REQ_ABORT);
        sent++;
      end
      phase++;
    end

    // one capture at the saturated depth on a single channel
    configure(11'd2047, 11'h7FA);
    calm = ($urandom_range(0, 1) == 0);
    send_ctrl(REQ_ARM);
    send_ctrl(REQ_KICK);
    repeat (DEF_BUFFER_DEPTH + 1) send_word();

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("round_robin_capture_demux_tb: PASS");
    end else begin
      $display("round_robin_capture_demux_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rrcd_pkg.sv
src/rrcd_core.sv
src/rrcd_out_reg.sv
src/round_robin_capture_demux.sv
tb/round_robin_capture_demux_checker.sv
tb/round_robin_capture_demux_tb.sv
